[hw/rtl/mfr_pkg.sv]
// Shared types, constants and byte compare helpers of the 3x3 RGB median filter.
// Used by every module of the block; depends on nothing.
package mfr_pkg;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int FW_W      = 12;
   localparam int FH_W      = 16;
   localparam int PIX_W     = 32;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_PRESENT = 2'd2;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       end_of_row;
      logic       end_of_frame;
   } rsp_type;

   // one window column, raw packed pixels, oldest row on top
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } col_type;

   // column sorted per channel (index 0 red, 1 green, 2 blue)
   typedef struct packed {
      logic [2:0][7:0] lo;
      logic [2:0][7:0] mi;
      logic [2:0][7:0] hi;
   } sorted_type;

   // per-item control that travels down the pipeline
   typedef struct packed {
      logic emit;
      logic border;
      logic eor;
      logic eof;
      logic alpha_en;
   } ctl_type;

   function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
      logic [7:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
      logic [7:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return (c < lo) ? lo : ((c > hi) ? hi : c);
   endfunction

endpackage

[hw/rtl/median_filter_3x3_rgb_unit.sv]
// 3x3 median filter over a raster RGBA stream. A result passes through the line
// store read, window cells, column merge and output register; results trail
// input by frame_width+1 beats. Throughput: one beat per cycle while rsp_ready
// does not stall the output, set by the single read port of the line store and
// the one-column-per-cycle shift of the window cells.
// Reset (synchronous): counters, valids and window clear; line store keeps junk.
module median_filter_3x3_rgb_unit #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mfr_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output mfr_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mfr_pkg::CSR_DAT_W-1:0]   csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int SW = $clog2(MAX_WIDTH + 2);
   localparam int FH = mfr_pkg::FH_W;

   // ---------------- configuration registers ----------------
   logic [mfr_pkg::FW_W-1:0] fwidth_ff;
   logic [FH-1:0]            fheight_ff;
   logic                     alpha_ff;
   logic                     csr_hit;

   assign csr_ready = 1'b1;

   always_comb begin
      unique case (csr_index) inside
         mfr_pkg::REG_FRAME_WIDTH,
         mfr_pkg::REG_FRAME_HEIGHT,
         mfr_pkg::REG_ALPHA_PRESENT: csr_hit = csr_valid;
         default:                    csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwidth_ff  <= 12'd640;
         fheight_ff <= 16'd480;
         alpha_ff   <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            mfr_pkg::REG_FRAME_WIDTH:   fwidth_ff  <= csr_data[mfr_pkg::FW_W-1:0];
            mfr_pkg::REG_FRAME_HEIGHT:  fheight_ff <= csr_data;
            mfr_pkg::REG_ALPHA_PRESENT: alpha_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // clamp width to 1..MAX_WIDTH, height to at least 1
   logic [WW-1:0] wid;
   logic [FH:0]   hgt;
   always_comb begin
      if (fwidth_ff == '0) begin
         wid = WW'(1);
      end else if (32'(fwidth_ff) > MAX_WIDTH) begin
         wid = WW'(MAX_WIDTH);
      end else begin
         wid = WW'(fwidth_ff);
      end
      hgt = (fheight_ff == '0) ? (FH+1)'(1) : {1'b0, fheight_ff};
   end

   // ---------------- pipeline handshakes ----------------
   logic v1_ff, v2_ff, v3_ff, out_v_ff;
   logic fr1, fr2, fr3, out_en, accept, mv1;

   assign out_en    = !out_v_ff || rsp_ready;
   assign fr3       = !v3_ff || out_en;
   assign fr2       = !v2_ff || fr3;
   assign fr1       = !v1_ff || fr2;
   assign req_ready = fr1;
   assign accept    = req_valid && req_ready;
   assign mv1       = v1_ff && fr2;

   // ---------------- frame position, decided at accept ----------------
   logic [AW-1:0] col_ff, col_in, c;
   logic [FH-1:0] row_ff, row_in;
   logic [SW-1:0] seen_ff, seen_in;
   logic [WW-1:0] ocol;
   logic [WW:0]   c_next;
   mfr_pkg::ctl_type ctl0;

   always_comb begin
      c      = ({1'b0, col_ff} >= (AW+1)'(wid)) ? '0 : col_ff;
      c_next = (WW+1)'(c) + (WW+1)'(1);
      ocol   = (c == '0) ? (wid - WW'(1)) : (WW'(c) - WW'(1));

      ctl0.emit     = ((SW+1)'(seen_ff) >= (SW+1)'(wid) + (SW+1)'(1));
      ctl0.eor      = ((WW+1)'(ocol) + (WW+1)'(1) >= (WW+1)'(wid));
      ctl0.eof      = ctl0.eor && ((FH+1)'(row_ff) + (FH+1)'(1) >= hgt);
      ctl0.border   = (row_ff == '0) || ((FH+1)'(row_ff) + (FH+1)'(1) >= hgt) ||
                      (ocol == '0) || ctl0.eor;
      ctl0.alpha_en = alpha_ff;

      col_in  = col_ff;
      row_in  = row_ff;
      seen_in = seen_ff;
      if (csr_hit) begin
         // any register write restarts the frame position
         col_in  = '0;
         row_in  = '0;
         seen_in = '0;
      end else if (accept) begin
         col_in = (c_next >= (WW+1)'(wid)) ? '0 : AW'(c_next);
         if (!ctl0.emit) begin
            seen_in = seen_ff + SW'(1);
         end else if (ctl0.eof) begin
            col_in  = '0;
            row_in  = '0;
            seen_in = '0;
         end else if (ctl0.eor) begin
            row_in = row_ff + FH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         seen_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         seen_ff <= seen_in;
      end
   end

   // ---------------- stage 1: line store read ----------------
   logic [mfr_pkg::PIX_W-1:0]   pix0, pix1_ff, top1, mid1;
   logic [AW-1:0]               c1_ff;
   mfr_pkg::ctl_type            ctl1_ff;
   logic                        byp_ff;
   logic [2*mfr_pkg::PIX_W-1:0] byp_data_ff, rd_data, wr_data;

   // a drain beat moves the window like an all-zero pixel
   assign pix0 = (req_data.kind == mfr_pkg::KIND_PIXEL) ?
                 {req_data.in_alpha, req_data.in_blue, req_data.in_green, req_data.in_red} :
                 '0;

   mfr_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_line_store (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (c),
      .rd_data_ff (rd_data),
      .wr_en      (mv1),
      .wr_addr    (c1_ff),
      .wr_data    (wr_data)
   );

   // same column read while the previous beat writes it: forward the write
   assign top1    = byp_ff ? byp_data_ff[2*mfr_pkg::PIX_W-1:mfr_pkg::PIX_W] :
                             rd_data[2*mfr_pkg::PIX_W-1:mfr_pkg::PIX_W];
   assign mid1    = byp_ff ? byp_data_ff[mfr_pkg::PIX_W-1:0] :
                             rd_data[mfr_pkg::PIX_W-1:0];
   assign wr_data = {mid1, pix1_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (fr1) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff     <= pix0;
         c1_ff       <= c;
         ctl1_ff     <= ctl0;
         byp_ff      <= v1_ff && (c1_ff == c);
         byp_data_ff <= wr_data;
      end
   end

   // ---------------- stage 2: window column cells ----------------
   mfr_pkg::col_type    col_feed [3];
   mfr_pkg::col_type    col_held [3];
   mfr_pkg::sorted_type col_sort [3];
   mfr_pkg::ctl_type    ctl2_ff;

   assign col_feed[2] = '{top: top1, mid: mid1, bot: pix1_ff};
   assign col_feed[1] = col_held[2];
   assign col_feed[0] = col_held[1];

   for (genvar k = 0; k < 3; k++) begin : g_cell
      mfr_column_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .load   (mv1),
         .col_in (col_feed[k]),
         .col_ff (col_held[k]),
         .sorted (col_sort[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (fr2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mv1) begin
         ctl2_ff <= ctl1_ff;
      end
   end

   // ---------------- stage 3: merge the sorted columns ----------------
   logic [2:0][7:0]           lo3_ff, mi3_ff, hi3_ff;
   logic [mfr_pkg::PIX_W-1:0] center3_ff;
   mfr_pkg::ctl_type          ctl3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (fr3) begin
         v3_ff <= v2_ff;
      end
   end

   // median = med(max of lows, med of mids, min of highs)
   always_ff @(posedge clock) begin
      if (fr3 && v2_ff) begin
         for (int ch = 0; ch < 3; ch++) begin
            lo3_ff[ch] <= mfr_pkg::max3(col_sort[0].lo[ch], col_sort[1].lo[ch],
                                        col_sort[2].lo[ch]);
            mi3_ff[ch] <= mfr_pkg::med3(col_sort[0].mi[ch], col_sort[1].mi[ch],
                                        col_sort[2].mi[ch]);
            hi3_ff[ch] <= mfr_pkg::min3(col_sort[0].hi[ch], col_sort[1].hi[ch],
                                        col_sort[2].hi[ch]);
         end
         center3_ff <= col_held[1].mid;
         ctl3_ff    <= ctl2_ff;
      end
   end

   // ---------------- output register ----------------
   mfr_pkg::rsp_type rsp_in;
   mfr_pkg::rsp_type rsp_ff;

   always_comb begin
      rsp_in.out_red   = ctl3_ff.border ? center3_ff[7:0] :
                         mfr_pkg::med3(lo3_ff[0], mi3_ff[0], hi3_ff[0]);
      rsp_in.out_green = ctl3_ff.border ? center3_ff[15:8] :
                         mfr_pkg::med3(lo3_ff[1], mi3_ff[1], hi3_ff[1]);
      rsp_in.out_blue  = ctl3_ff.border ? center3_ff[23:16] :
                         mfr_pkg::med3(lo3_ff[2], mi3_ff[2], hi3_ff[2]);
      rsp_in.out_alpha    = ctl3_ff.alpha_en ? center3_ff[31:24] : 8'd0;
      rsp_in.end_of_row   = ctl3_ff.eor;
      rsp_in.end_of_frame = ctl3_ff.eof;
   end

   // drop beats that only fill the window
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_en) begin
         out_v_ff <= v3_ff && ctl3_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && v3_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- assertions ----------------
   a_eof_ends_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.end_of_frame || rsp_data.end_of_row))
      else $error("end_of_frame without end_of_row");

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      (SW+1)'(seen_ff) <= (SW+1)'(wid) + (SW+1)'(1))
      else $error("item count past width+1");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_ready)
      else $error("input stalled with empty first stage");

endmodule

[hw/rtl/mfr_line_store.sv]
// Two-row line buffer: one word per column holds {older row, newer row} pixels.
// One write port, one read port with registered data. Uses mfr_pkg.
module mfr_line_store #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [2*mfr_pkg::PIX_W-1:0]  rd_data_ff,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [2*mfr_pkg::PIX_W-1:0]  wr_data
);

   logic [2*mfr_pkg::PIX_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

[hw/rtl/mfr_column_cell.sv]
// One column of the 3x3 window: holds the raw column, hands it to the older
// neighbor and presents it sorted per channel. Uses mfr_pkg.
module mfr_column_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mfr_pkg::col_type     col_in,
   output mfr_pkg::col_type     col_ff,
   output mfr_pkg::sorted_type  sorted
);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (load) begin
         col_ff <= col_in;
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sorted.lo[ch] = mfr_pkg::min3(col_ff.top[8*ch +: 8], col_ff.mid[8*ch +: 8],
                                       col_ff.bot[8*ch +: 8]);
         sorted.mi[ch] = mfr_pkg::med3(col_ff.top[8*ch +: 8], col_ff.mid[8*ch +: 8],
                                       col_ff.bot[8*ch +: 8]);
         sorted.hi[ch] = mfr_pkg::max3(col_ff.top[8*ch +: 8], col_ff.mid[8*ch +: 8],
                                       col_ff.bot[8*ch +: 8]);
      end
   end

endmodule
